FILE: rtl/core/tie_break_priority_queue_macros.svh
// assertion macros for the tie-break priority queue checker
// no dependencies; included by the checker file only
`ifndef TIE_BREAK_PRIORITY_QUEUE_MACROS_SVH
`define TIE_BREAK_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication under reset
`define TBPQ_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define TBPQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tbpq_pkg.sv
// shared types, field widths, codes and the ordering function
// of the tie-break priority queue; no dependencies
package tbpq_pkg;

    localparam int ID_W     = 8;
    localparam int PRIO_W   = 32;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic
    {
        TIE_ARRIVAL = 1'b0,
        TIE_LOW_ID  = 1'b1
    } tie_mode_t;

    // one stored entry
    typedef struct packed
    {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // write command from the control to every cell
    typedef struct packed
    {
        logic   wr_push;   // store at slot count, start sift up
        logic   wr_pop;    // store at root, maybe start sift down
        logic   dn_start;
        entry_t wr_entry;
    } cell_load_t;

    // what a cell shows its parent and children
    typedef struct packed
    {
        entry_t ent;
        logic   up_swap;   // swapping with parent this cycle
        logic   dn_left;   // swapping with left child this cycle
        logic   dn_right;  // swapping with right child this cycle
        logic   busy;      // holds a sift token
    } cell_link_t;

    // true when a must leave before b
    function automatic logic goes_first(entry_t a, entry_t b, logic mode);
        logic res;
        if (a.prio != b.prio)
        begin
            res = a.prio < b.prio;
        end
        else if (mode == TIE_LOW_ID)
        begin
            res = a.id < b.id;
        end
        else
        begin
            res = a.stamp < b.stamp;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/tbpq_channels.sv
// valid/ready channel interfaces for requests and results
// depends on tbpq_pkg for field widths
interface tbpq_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [tbpq_pkg::ID_W-1:0]   entry_id;
    logic [tbpq_pkg::PRIO_W-1:0] priority_req;

    modport source (output valid, opcode, entry_id, priority_req, input ready);
    modport sink   (input valid, opcode, entry_id, priority_req, output ready);
endinterface

interface tbpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tbpq_pkg::STATUS_W-1:0] status;
    logic [tbpq_pkg::ID_W-1:0]     popped_id;
    logic [tbpq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, popped_id, occupancy, input ready);
    modport sink   (input valid, status, popped_id, occupancy, output ready);
endinterface

FILE: rtl/core/tbpq_cell.sv
// one heap slot: holds an entry and a sift token, swaps with its
// parent or a child one level a cycle; depends on tbpq_pkg
module tbpq_cell #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic [CNT_W-1:0]     count,
    input  tbpq_pkg::cell_load_t load,
    input  tbpq_pkg::cell_link_t parent,
    input  tbpq_pkg::cell_link_t left,
    input  tbpq_pkg::cell_link_t right,
    output tbpq_pkg::cell_link_t link
);

    localparam int L          = 2 * IDX + 1;
    localparam int R          = 2 * IDX + 2;
    localparam bit L_EXISTS   = (L < CAPACITY);
    localparam bit R_EXISTS   = (R < CAPACITY);
    localparam bit IS_ROOT    = (IDX == 0);
    localparam bit IS_LEFT    = ((IDX % 2) == 1);

    tbpq_pkg::entry_t ent_reg;
    tbpq_pkg::entry_t ent_next;
    logic             up_tok_reg;
    logic             up_tok_next;
    logic             dn_tok_reg;
    logic             dn_tok_next;

    logic             hit_push;
    logic             hit_pop;
    logic             has_l;
    logic             has_r;
    logic             pick_l;
    logic             pick_r;
    tbpq_pkg::entry_t best_ent;
    logic             dn_left;
    logic             dn_right;
    logic             up_swap;
    logic             from_parent;
    logic             child_up;

    // write targets from the control
    assign hit_push = load.wr_push && (count == CNT_W'(IDX));
    assign hit_pop  = load.wr_pop && IS_ROOT;

    // children inside the live part of the heap
    assign has_l = L_EXISTS && (count > CNT_W'(L));
    assign has_r = R_EXISTS && (count > CNT_W'(R));

    // sift down choice, same order of tests as a software heap
    always_comb
    begin
        pick_l   = has_l && tbpq_pkg::goes_first(left.ent, ent_reg, mode);
        best_ent = pick_l ? left.ent : ent_reg;
        pick_r   = has_r && tbpq_pkg::goes_first(right.ent, best_ent, mode);
    end

    assign dn_right = dn_tok_reg && pick_r;
    assign dn_left  = dn_tok_reg && pick_l && !pick_r;

    // sift up choice
    assign up_swap = up_tok_reg && !IS_ROOT && tbpq_pkg::goes_first(ent_reg, parent.ent, mode);

    // neighbors moving data into this slot
    assign from_parent = IS_LEFT ? parent.dn_left : parent.dn_right;
    assign child_up    = left.up_swap || right.up_swap;

    // next entry
    always_comb
    begin
        ent_next = ent_reg;
        if (hit_push || hit_pop)
        begin
            ent_next = load.wr_entry;
        end
        else if (dn_left)
        begin
            ent_next = left.ent;
        end
        else if (dn_right)
        begin
            ent_next = right.ent;
        end
        else if (up_swap || from_parent)
        begin
            ent_next = parent.ent;
        end
        else if (left.up_swap)
        begin
            ent_next = left.ent;
        end
        else if (right.up_swap)
        begin
            ent_next = right.ent;
        end
    end

    // tokens move with the item being sifted
    assign up_tok_next = hit_push || child_up;
    assign dn_tok_next = (hit_pop && load.dn_start) || from_parent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_tok_reg <= 1'b0;
            dn_tok_reg <= 1'b0;
        end
        else
        begin
            up_tok_reg <= up_tok_next;
            dn_tok_reg <= dn_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    // outputs to neighbors
    always_comb
    begin
        link.ent      = ent_reg;
        link.up_swap  = up_swap;
        link.dn_left  = dn_left;
        link.dn_right = dn_right;
        link.busy     = up_tok_reg || dn_tok_reg;
    end

endmodule

FILE: rtl/core/tie_break_priority_queue.sv
// channel | dir | beat carries
// req     | in  | opcode, entry_id, priority_req
// rsp     | out | status, popped_id, occupancy
// cfg     | in  | cfg_we, cfg_wdata (tie_break_mode)
//
// a beat's result is registered for the next cycle; a push then sifts up and
// a pop sifts down one heap level a cycle, moved by the sift token walk.
// req.ready drops while a sift runs or a result waits on a stalled rsp.
// reset clears the count, arrival stamp, mode, result valid and tokens; slot
// contents stay undefined and need no clearing pass.
//
// top level: control, arrival stamp and a heap of tbpq_cell slots
// depends on tbpq_pkg, tbpq_channels and tbpq_cell
module tie_break_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    tbpq_req_if.sink          req,
    tbpq_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [tbpq_pkg::STAMP_W-1:0] stamp_reg;
    logic [tbpq_pkg::STAMP_W-1:0] stamp_next;
    logic                         mode_reg;

    logic                          rsp_valid_reg;
    logic [tbpq_pkg::STATUS_W-1:0] status_reg;
    logic [tbpq_pkg::STATUS_W-1:0] status_next;
    logic [tbpq_pkg::ID_W-1:0]     popped_reg;
    logic [tbpq_pkg::ID_W-1:0]     popped_next;
    logic [tbpq_pkg::OCC_W-1:0]    occ_reg;
    logic [CNT_W+tbpq_pkg::OCC_W-1:0] occ_wide;

    tbpq_pkg::cell_link_t links [CAPACITY];
    tbpq_pkg::cell_load_t load;
    tbpq_pkg::entry_t     push_ent;
    logic [CAPACITY-1:0]  busy_vec;
    logic                 busy;
    logic                 accept;
    logic                 is_full;
    logic                 is_empty;
    logic [CNT_W-1:0]     cnt_m1;
    logic [IDX_W-1:0]     last_idx;

    // handshake
    assign busy      = |busy_vec;
    assign req.ready = !busy && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign cnt_m1   = count_reg - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];

    assign push_ent.id    = req.entry_id;
    assign push_ent.prio  = req.priority_req;
    assign push_ent.stamp = stamp_reg;

    // operation decode and slot writes
    always_comb
    begin
        count_next    = count_reg;
        stamp_next    = stamp_reg;
        status_next   = tbpq_pkg::STATUS_OK;
        popped_next   = '0;
        load.wr_push  = 1'b0;
        load.wr_pop   = 1'b0;
        load.dn_start = 1'b0;
        load.wr_entry = push_ent;
        if (accept)
        begin
            if (req.opcode == tbpq_pkg::OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = tbpq_pkg::STATUS_FULL;
                end
                else
                begin
                    load.wr_push = 1'b1;
                    count_next   = count_reg + 1'b1;
                    stamp_next   = stamp_reg + 1'b1;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = tbpq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    popped_next   = links[0].ent.id;
                    load.wr_pop   = 1'b1;
                    load.dn_start = (cnt_m1 != '0);
                    load.wr_entry = links[last_idx].ent;
                    count_next    = cnt_m1;
                end
            end
        end
    end

    // occupancy masked to the field width
    assign occ_wide = {{tbpq_pkg::OCC_W{1'b0}}, count_next};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            stamp_reg     <= '0;
            mode_reg      <= tbpq_pkg::TIE_ARRIVAL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            stamp_reg <= stamp_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            occ_reg    <= occ_wide[tbpq_pkg::OCC_W-1:0];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.popped_id = popped_reg;
    assign rsp.occupancy = occ_reg;

    // heap of slots, each wired to its parent and children
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        tbpq_pkg::cell_link_t par_link;
        tbpq_pkg::cell_link_t l_link;
        tbpq_pkg::cell_link_t r_link;

        if (gi > 0)
        begin : g_par
            assign par_link = links[(gi - 1) / 2];
        end
        else
        begin : g_nopar
            assign par_link = '0;
        end

        if (2 * gi + 1 < CAPACITY)
        begin : g_l
            assign l_link = links[2 * gi + 1];
        end
        else
        begin : g_nol
            assign l_link = '0;
        end

        if (2 * gi + 2 < CAPACITY)
        begin : g_r
            assign r_link = links[2 * gi + 2];
        end
        else
        begin : g_nor
            assign r_link = '0;
        end

        tbpq_cell #(
            .CAPACITY (CAPACITY),
            .CNT_W    (CNT_W),
            .IDX      (gi)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .mode   (mode_reg),
            .count  (count_reg),
            .load   (load),
            .parent (par_link),
            .left   (l_link),
            .right  (r_link),
            .link   (links[gi])
        );

        assign busy_vec[gi] = links[gi].busy;
    end

endmodule

FILE: rtl/core/tbpq_checker.sv
// port-level checks of the tie-break priority queue and its bind
// depends on tbpq_pkg and tie_break_priority_queue_macros.svh
`include "tie_break_priority_queue_macros.svh"

module tbpq_port_checks (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [tbpq_pkg::STATUS_W-1:0] status,
    input logic [tbpq_pkg::ID_W-1:0]     popped_id,
    input logic [tbpq_pkg::OCC_W-1:0]    occupancy
);

    // stalled result beat holds
    `TBPQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(popped_id) && $stable(occupancy), "stalled result changed")

    // every accepted request gives a result on the next cycle
    `TBPQ_ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_valid && req_ready, rsp_valid, "accepted request gave no result")

    // no new request while a result is stuck
    `TBPQ_ASSERT_NOW(a_no_overrun, clk, rst_n, rsp_valid && !rsp_ready, !req_ready, "request taken over a stalled result")

    // a rejected pop reports an empty queue and no id
    `TBPQ_ASSERT_NOW(a_empty_pop, clk, rst_n, rsp_valid && (status == tbpq_pkg::STATUS_EMPTY), (occupancy == '0) && (popped_id == '0), "empty pop with id or occupancy")

endmodule

bind tie_break_priority_queue tbpq_port_checks u_tbpq_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .popped_id (rsp.popped_id),
    .occupancy (rsp.occupancy)
);
